// ===== src/emd_pkg.sv =====
// Shared types and constants of the energy meter packet decoder.
`timescale 1ns / 1ps
`default_nettype none

package emd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ENERGY_W  = 48;
  localparam int unsigned DATA_LEN  = 18;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned GAIN_FRACTION_BITS = 16;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h55;

  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_NUMERATOR = 3'd4;

  localparam logic [WORD_W-1:0] GAIN_RESET     = 24'd65536;
  localparam logic [WORD_W-1:0] FREQ_NUM_RESET = 24'd1000000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== src/emd_div.sv =====
// Bit-serial restoring divider for the frequency quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module emd_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [emd_pkg::WORD_W-1:0]    dividend_i,
  input  wire logic [emd_pkg::WORD_W-1:0]    divisor_i,
  output emd_pkg::div_stat_t                 stat_o,
  output logic      [emd_pkg::WORD_W-1:0]    quotient_o
);

  localparam int unsigned W     = emd_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             zero_q;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     div_q;
  logic [W:0]       trial;
  logic [W:0]       diff;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(W);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end
  end

  assign stat_o     = '{busy: (cnt_q != '0), done: done_q};
  assign quotient_o = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire

// ===== src/energy_meter_packet_decoder.sv =====
// Top level: frame hunting, byte collection and the shared multiply sequencer.
// Ready stays high while data bytes are collected, so they can arrive one per cycle.
// The last data byte starts the work: four passes through one 24x24 multiplier,
// a 24-step bit-serial divide with a registered done flag, and the output load.
// Ready returns when the result is loaded, or once a held result has been taken.
// Reset clears the byte position, energy total and output valid, and restores the gains.
`timescale 1ns / 1ps
`default_nettype none

module energy_meter_packet_decoder #(
  parameter int unsigned GAIN_FRACTION_BITS = emd_pkg::GAIN_FRACTION_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [emd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [emd_pkg::WORD_W-1:0]            cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [emd_pkg::BYTE_W-1:0]            rx_byte_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [emd_pkg::VALUE_W-1:0]                current_value_o,
  output logic [emd_pkg::VALUE_W-1:0]                voltage_value_o,
  output logic [emd_pkg::VALUE_W-1:0]                power_value_o,
  output logic [emd_pkg::ENERGY_W-1:0]               energy_total_o,
  output logic [emd_pkg::WORD_W-1:0]                 frequency_value_o
);

  localparam int unsigned W      = emd_pkg::WORD_W;
  localparam int unsigned VW     = emd_pkg::VALUE_W;
  localparam int unsigned EW     = emd_pkg::ENERGY_W;
  localparam int unsigned PROD_W = 2 * W;
  localparam int unsigned NBYTES = emd_pkg::DATA_LEN;
  localparam int unsigned PW     = emd_pkg::POS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_POST = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [1:0]    idx_q, idx_d;

  logic [W-1:0] cur_gain_q, vol_gain_q, pow_gain_q, eng_gain_q, freq_num_q;

  logic [emd_pkg::BYTE_W-1:0] frame_q [NBYTES];

  logic [W-1:0]      word_cur, word_vol, word_pow, word_eng, word_per, pow_mag;
  logic [W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] scaled;
  logic [VW-1:0]     scaled_sat;
  logic [EW:0]       energy_ext;

  logic [VW-1:0] cur_q, vol_q, pow_q;
  logic [W-1:0]  freq_q;
  logic [EW-1:0] energy_sum_q;

  logic               accept;
  logic               frame_end;
  logic               hunting;
  logic               div_start;
  logic [W-1:0]       div_quo;
  emd_pkg::div_stat_t div_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign hunting    = (pos_q == '0) || (pos_q > PW'(NBYTES));
  assign frame_end  = accept && !hunting && (pos_q == PW'(NBYTES));
  assign div_start  = (state_q == ST_POST) && (idx_q == 2'd3);

  assign word_cur = {frame_q[2],  frame_q[1],  frame_q[0]};
  assign word_vol = {frame_q[5],  frame_q[4],  frame_q[3]};
  assign word_pow = {frame_q[11], frame_q[10], frame_q[9]};
  assign word_eng = {frame_q[14], frame_q[13], frame_q[12]};
  assign word_per = {frame_q[17], frame_q[16], frame_q[15]};
  assign pow_mag  = word_pow[W-1] ? (W'(0) - word_pow) : word_pow;

  always_comb begin
    case (idx_q)
      2'd0: begin
        mul_a = word_cur;
        mul_b = cur_gain_q;
      end
      2'd1: begin
        mul_a = word_vol;
        mul_b = vol_gain_q;
      end
      2'd2: begin
        mul_a = pow_mag;
        mul_b = pow_gain_q;
      end
      default: begin
        mul_a = word_eng;
        mul_b = eng_gain_q;
      end
    endcase
  end

  assign scaled     = prod_q >> GAIN_FRACTION_BITS;
  assign scaled_sat = (|scaled[PROD_W-1:VW]) ? '1 : scaled[VW-1:0];
  assign energy_ext = {1'b0, energy_sum_q} + {1'b0, scaled[EW-1:0]};

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (hunting) begin
            pos_d = (rx_byte_i == emd_pkg::HDR_BYTE) ? PW'(1) : '0;
          end else if (pos_q < PW'(NBYTES)) begin
            pos_d = pos_q + PW'(1);
          end else begin
            pos_d   = '0;
            idx_d   = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_POST;
      end
      ST_POST: begin
        if (idx_q == 2'd3) begin
          state_d = ST_DIV;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      idx_q        <= '0;
      energy_sum_q <= '0;
      out_valid_o  <= 1'b0;
      cur_gain_q   <= emd_pkg::GAIN_RESET;
      vol_gain_q   <= emd_pkg::GAIN_RESET;
      pow_gain_q   <= emd_pkg::GAIN_RESET;
      eng_gain_q   <= emd_pkg::GAIN_RESET;
      freq_num_q   <= emd_pkg::FREQ_NUM_RESET;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      if (div_start) begin
        energy_sum_q <= energy_ext[EW] ? '1 : energy_ext[EW-1:0];
      end
      if (state_q == ST_PUSH && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          emd_pkg::REG_CURRENT_GAIN:   cur_gain_q <= cfg_wdata_i;
          emd_pkg::REG_VOLTAGE_GAIN:   vol_gain_q <= cfg_wdata_i;
          emd_pkg::REG_POWER_GAIN:     pow_gain_q <= cfg_wdata_i;
          emd_pkg::REG_ENERGY_GAIN:    eng_gain_q <= cfg_wdata_i;
          emd_pkg::REG_FREQ_NUMERATOR: freq_num_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !hunting) begin
      for (int i = 0; i < NBYTES - 1; i++) begin
        frame_q[i] <= frame_q[i+1];
      end
      frame_q[NBYTES-1] <= rx_byte_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= {{(PROD_W-W){1'b0}}, mul_a} * {{(PROD_W-W){1'b0}}, mul_b};
    end
    if (state_q == ST_POST) begin
      case (idx_q)
        2'd0:    cur_q <= scaled_sat;
        2'd1:    vol_q <= scaled_sat;
        2'd2:    pow_q <= scaled_sat;
        default: begin
        end
      endcase
    end
    if (state_q == ST_DIV && div_stat.done) begin
      freq_q <= div_quo;
    end
    if (state_q == ST_PUSH && (!out_valid_o || out_ready_i)) begin
      current_value_o   <= cur_q;
      voltage_value_o   <= vol_q;
      power_value_o     <= pow_q;
      energy_total_o    <= energy_sum_q;
      frequency_value_o <= freq_q;
    end
  end

  emd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (freq_num_q),
    .divisor_i  (word_per),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // The byte position never leaves the range of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PW'(NBYTES))
    else $error("byte position out of range");

  // The divider runs only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("divider active outside its wait state");

  // The saturating energy total never decreases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (energy_sum_q >= $past(energy_sum_q)))
    else $error("energy total decreased");

  // The end of a frame starts the multiply sequence with the current word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> (state_q == ST_MUL) && (idx_q == 2'd0))
    else $error("frame end did not start the multiply sequence");

endmodule

`default_nettype wire
